FILE: rtl/qpsf_pkg.sv
// Package for the QPACK static field section parser.
// Holds parse phases, token and error codes, the token struct and limits.
// No dependencies; imported by every module of the parser.
package qpsf_pkg;

  // Static table size and continuation limit of a prefixed integer
  localparam int STATIC_ENTRIES  = 99;
  localparam int MAX_CONT_OCTETS = 10;

  // Prefixed integer limits: values stay below 2^62, 7 bits per octet
  localparam int QINT_BITS        = 62;
  localparam int GROUP_BITS       = 7;
  localparam int CONT_SHIFT_LIMIT = (QINT_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int CONT_W           = 4;
  localparam int SHIFT_W          = 7;

  // Output queue depth
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Token kinds
  localparam logic [2:0] KIND_INDEXED    = 3'd0;
  localparam logic [2:0] KIND_NAME_REF   = 3'd1;
  localparam logic [2:0] KIND_NAME_BYTE  = 3'd2;
  localparam logic [2:0] KIND_VALUE_BYTE = 3'd3;
  localparam logic [2:0] KIND_DONE       = 3'd4;
  localparam logic [2:0] KIND_ERROR      = 3'd5;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_PREFIX    = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
  localparam logic [2:0] ERR_DYNAMIC   = 3'd3;
  localparam logic [2:0] ERR_RANGE     = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  // Parse phases
  typedef enum logic [3:0] {
    PH_RIC           = 4'd0,
    PH_DB_FIRST      = 4'd1,
    PH_DB_CONT       = 4'd2,
    PH_LINE          = 4'd3,
    PH_IDX_CONT      = 4'd4,
    PH_NREF_CONT     = 4'd5,
    PH_NAME_LEN_CONT = 4'd6,
    PH_NAME_BYTES    = 4'd7,
    PH_VAL_LEN_FIRST = 4'd8,
    PH_VAL_LEN_CONT  = 4'd9,
    PH_VAL_BYTES     = 4'd10,
    PH_DRAIN         = 4'd11
  } phase_t;

  // One result token
  typedef struct packed {
    logic [2:0] token_kind;
    logic [6:0] static_index;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       huffman_coded;
    logic       never_indexed;
    logic       string_end;
    logic [2:0] error_code;
    logic       run_last;
  } token_t;

  // Tokens handed together from the parser to the output queue
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

FILE: rtl/qpsf_parser.sv
// Parser core: input register, parse state and token generation.
// Produces up to two tokens per octet for the output queue.
// Depends on qpsf_pkg.
module qpsf_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,   // [7:0] byte_in
  input  logic           s_tlast,   // last_byte
  input  logic           room,
  output qpsf_pkg::push_t push
);
  import qpsf_pkg::*;

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       go;

  // Parse state
  phase_t                 phase, phase_next;
  logic [QINT_BITS-1:0]   accum, accum_next;
  logic [CONT_W-1:0]      cont, cont_next;
  logic [QINT_BITS-1:0]   left, left_next;
  logic [1:0]             flags, flags_next;   // bit0 N, bit1 H
  logic [2:0]             err, err_next;
  logic                   had_err;

  // Continuation step
  logic [6:0]             grp;
  logic [SHIFT_W-1:0]     sh;
  logic [63:0]            shifted;
  logic [63:0]            sum;
  logic [QINT_BITS-1:0]   stepped;
  logic [CONT_W-1:0]      cont_inc;
  logic                   step_ovf;
  logic                   step_done;

  // Decoded results of this octet
  logic                   fin_idx, fin_nref;
  logic                   fin_len, fin_value;
  logic [QINT_BITS-1:0]   fin_val;
  logic                   raise;
  logic [2:0]             raise_code;
  logic                   a_v;
  token_t                 tok_a;
  logic                   b_v;
  token_t                 tok_b;

  assign go       = in_valid && room;
  assign s_tready = !in_valid || go;
  assign had_err  = (err != ERR_NONE);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // One continuation octet of a prefixed integer
  always_comb begin
    grp       = in_byte[6:0];
    sh        = SHIFT_W'(cont) * SHIFT_W'(GROUP_BITS);
    shifted   = {57'd0, grp} << sh;
    sum       = {{(64-QINT_BITS){1'b0}}, accum} + shifted;
    step_ovf  = (grp != 7'd0) &&
                ((cont >= CONT_W'(CONT_SHIFT_LIMIT)) || (sum[63:QINT_BITS] != '0));
    stepped   = (grp != 7'd0) ? sum[QINT_BITS-1:0] : accum;
    cont_inc  = cont + CONT_W'(1);
    step_done = !step_ovf && !in_byte[7];
    step_ovf  = step_ovf || (in_byte[7] && (cont_inc >= CONT_W'(MAX_CONT_OCTETS)));
  end

  // Decode: next parse state and the first token of this octet
  always_comb begin
    phase_next = phase;
    accum_next = accum;
    cont_next  = cont;
    left_next  = left;
    flags_next = flags;
    err_next   = err;
    fin_idx    = 1'b0;
    fin_nref   = 1'b0;
    fin_len    = 1'b0;
    fin_value  = 1'b0;
    fin_val    = '0;
    raise      = 1'b0;
    raise_code = ERR_NONE;
    a_v        = 1'b0;
    tok_a      = '0;

    if (!had_err) begin
      case (phase)
        PH_RIC: begin
          if (in_byte != 8'h00) begin
            raise = 1'b1; raise_code = ERR_PREFIX;
          end else begin
            phase_next = PH_DB_FIRST;
          end
        end
        PH_DB_FIRST: begin
          if (in_byte[7]) begin
            raise = 1'b1; raise_code = ERR_PREFIX;
          end else begin
            accum_next = QINT_BITS'(in_byte[6:0]);
            cont_next  = '0;
            phase_next = (in_byte[6:0] != 7'h7f) ? PH_LINE : PH_DB_CONT;
          end
        end
        PH_DB_CONT: begin
          if (step_ovf) begin
            raise = 1'b1; raise_code = ERR_OVERFLOW;
          end else begin
            accum_next = stepped;
            cont_next  = cont_inc;
            if (step_done) phase_next = PH_LINE;
          end
        end
        PH_LINE: begin
          flags_next = 2'b00;
          if (in_byte[7]) begin
            // indexed field line
            if (!in_byte[6]) begin
              raise = 1'b1; raise_code = ERR_DYNAMIC;
            end else begin
              accum_next = QINT_BITS'(in_byte[5:0]);
              cont_next  = '0;
              if (in_byte[5:0] != 6'h3f) begin
                fin_idx = 1'b1;
                fin_val = QINT_BITS'(in_byte[5:0]);
              end else begin
                phase_next = PH_IDX_CONT;
              end
            end
          end else if (in_byte[6]) begin
            // literal with name reference
            if (!in_byte[4]) begin
              raise = 1'b1; raise_code = ERR_DYNAMIC;
            end else begin
              flags_next = {1'b0, in_byte[5]};
              accum_next = QINT_BITS'(in_byte[3:0]);
              cont_next  = '0;
              if (in_byte[3:0] != 4'hf) begin
                fin_idx  = 1'b1;
                fin_nref = 1'b1;
                fin_val  = QINT_BITS'(in_byte[3:0]);
              end else begin
                phase_next = PH_NREF_CONT;
              end
            end
          end else if (in_byte[5]) begin
            // literal with literal name
            flags_next = {in_byte[3], in_byte[4]};
            accum_next = QINT_BITS'(in_byte[2:0]);
            cont_next  = '0;
            if (in_byte[2:0] != 3'h7) begin
              fin_len = 1'b1;
              fin_val = QINT_BITS'(in_byte[2:0]);
            end else begin
              phase_next = PH_NAME_LEN_CONT;
            end
          end else begin
            raise = 1'b1; raise_code = ERR_DYNAMIC;
          end
        end
        PH_IDX_CONT, PH_NREF_CONT: begin
          if (step_ovf) begin
            raise = 1'b1; raise_code = ERR_OVERFLOW;
          end else begin
            accum_next = stepped;
            cont_next  = cont_inc;
            if (step_done) begin
              fin_idx  = 1'b1;
              fin_nref = (phase == PH_NREF_CONT);
              fin_val  = stepped;
            end
          end
        end
        PH_NAME_LEN_CONT, PH_VAL_LEN_CONT: begin
          if (step_ovf) begin
            raise = 1'b1; raise_code = ERR_OVERFLOW;
          end else begin
            accum_next = stepped;
            cont_next  = cont_inc;
            if (step_done) begin
              fin_len   = 1'b1;
              fin_value = (phase == PH_VAL_LEN_CONT);
              fin_val   = stepped;
            end
          end
        end
        PH_VAL_LEN_FIRST: begin
          flags_next = {in_byte[7], flags[0]};
          accum_next = QINT_BITS'(in_byte[6:0]);
          cont_next  = '0;
          if (in_byte[6:0] != 7'h7f) begin
            fin_len   = 1'b1;
            fin_value = 1'b1;
            fin_val   = QINT_BITS'(in_byte[6:0]);
          end else begin
            phase_next = PH_VAL_LEN_CONT;
          end
        end
        PH_NAME_BYTES, PH_VAL_BYTES: begin
          a_v                 = 1'b1;
          tok_a.token_kind    = (phase == PH_VAL_BYTES) ? KIND_VALUE_BYTE : KIND_NAME_BYTE;
          tok_a.data_byte     = in_byte;
          tok_a.byte_valid    = 1'b1;
          tok_a.huffman_coded = flags[1];
          tok_a.never_indexed = flags[0];
          tok_a.string_end    = (left <= QINT_BITS'(1));
          if (left <= QINT_BITS'(1)) begin
            left_next  = '0;
            phase_next = (phase == PH_VAL_BYTES) ? PH_LINE : PH_VAL_LEN_FIRST;
          end else begin
            left_next  = left - QINT_BITS'(1);
          end
        end
        default: begin
          raise = 1'b1; raise_code = ERR_TRUNCATED;
        end
      endcase

      // Completed static index
      if (fin_idx) begin
        if (fin_val >= QINT_BITS'(STATIC_ENTRIES)) begin
          raise      = 1'b1;
          raise_code = ERR_RANGE;
        end else begin
          a_v                 = 1'b1;
          tok_a.token_kind    = fin_nref ? KIND_NAME_REF : KIND_INDEXED;
          tok_a.static_index  = fin_val[6:0];
          tok_a.never_indexed = fin_nref && flags_next[0];
          phase_next          = fin_nref ? PH_VAL_LEN_FIRST : PH_LINE;
        end
      end

      // Completed string length; an empty string gives one token
      if (fin_len) begin
        left_next = fin_val;
        if (fin_val == '0) begin
          a_v                 = 1'b1;
          tok_a.token_kind    = fin_value ? KIND_VALUE_BYTE : KIND_NAME_BYTE;
          tok_a.huffman_coded = flags_next[1];
          tok_a.never_indexed = flags_next[0];
          tok_a.string_end    = 1'b1;
          phase_next          = fin_value ? PH_LINE : PH_VAL_LEN_FIRST;
        end else begin
          phase_next          = fin_value ? PH_VAL_BYTES : PH_NAME_BYTES;
        end
      end

      // Error takes over the octet
      if (raise) begin
        err_next         = raise_code;
        phase_next       = PH_DRAIN;
        a_v              = 1'b1;
        tok_a            = '0;
        tok_a.token_kind = KIND_ERROR;
        tok_a.error_code = raise_code;
      end
    end
  end

  // State registers; the final octet of a section rearms the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIC;
      accum <= '0;
      cont  <= '0;
      left  <= '0;
      flags <= '0;
      err   <= ERR_NONE;
    end else if (go) begin
      if (in_last) begin
        phase <= PH_RIC;
        accum <= '0;
        cont  <= '0;
        left  <= '0;
        flags <= '0;
        err   <= ERR_NONE;
      end else begin
        phase <= phase_next;
        accum <= accum_next;
        cont  <= cont_next;
        left  <= left_next;
        flags <= flags_next;
        err   <= err_next;
      end
    end
  end

  // Section-end token and packing of the tokens for the queue
  always_comb begin
    b_v   = in_last && !had_err && (err_next == ERR_NONE);
    tok_b = '0;
    if (phase_next == PH_LINE) begin
      tok_b.token_kind = KIND_DONE;
    end else begin
      tok_b.token_kind = KIND_ERROR;
      tok_b.error_code = ERR_TRUNCATED;
    end
    tok_b.run_last = 1'b1;

    push.tok0          = a_v ? tok_a : tok_b;
    push.tok0.run_last = !(a_v && b_v);
    push.tok1          = tok_b;
    push.count         = go ? (2'(a_v) + 2'(b_v)) : 2'd0;
  end

endmodule

FILE: rtl/qpsf_out_fifo.sv
// Output token queue: takes up to two tokens a cycle, gives one a cycle while m_tready is high.
// Signals room while at least two entries are free.
// Depends on qpsf_pkg.
module qpsf_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  qpsf_pkg::push_t push,
  output logic            room,
  output logic            m_tvalid,
  input  logic            m_tready,
  output qpsf_pkg::token_t head
);
  import qpsf_pkg::*;

  token_t           entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign room     = (count <= (PTR_W+1)'(FIFO_DEPTH - 2));
  assign head     = entries[rd_ptr];

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.tok1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end
  end

endmodule

FILE: rtl/qpack_static_field_section_parser_unit.sv
// Channel  Dir  Payload                                   Transfer when
// s_*      in   tdata: byte_in; tlast: last_byte           s_tvalid && s_tready
// m_*      out  tdata: token fields; tuser: kind; tlast    m_tvalid && m_tready
//
// One octet per cycle sustained while the output queue has room: an input register feeds
// the parse logic, whose tokens (up to two per octet) go into a four-entry output queue.
// The tokens of an octet are written into the output queue before they appear on m_*.
// s_tready drops while an octet waits in the input register and the queue has
// fewer than two free entries.
// rst is synchronous, active high, and returns the parser to the section prefix.
//
// Top level of the QPACK static field section parser.
// Depends on qpsf_pkg, qpsf_parser and qpsf_out_fifo.
module qpack_static_field_section_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [6:0] static_index, [14:7] data_byte, [15] byte_valid,
                                 // [16] huffman_coded, [17] never_indexed,
                                 // [18] string_end, [21:19] error_code, [23:22] zero
  output logic [2:0]  m_tuser,   // [2:0] token_kind
  output logic        m_tlast    // run_last
);
  import qpsf_pkg::*;

  push_t  push;
  logic   room;
  token_t head;

  qpsf_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .room     (room),
    .push     (push)
  );

  qpsf_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  // Pack the head token onto the output channel
  assign m_tdata = {2'b00, head.error_code, head.string_end, head.never_indexed,
                    head.huffman_coded, head.byte_valid, head.data_byte,
                    head.static_index};
  assign m_tuser = head.token_kind;
  assign m_tlast = head.run_last;

endmodule

FILE: verif/tb_qpack_static_field_section_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for qpack_static_field_section_parser_unit.
// Depends on qpsf_pkg for token codes, parse phases and the token struct;
// sends encoded field sections and checks every token against its own parser.
module tb_qpack_static_field_section_parser_unit;
  import qpsf_pkg::*;

  localparam logic [63:0] QINT_MAX   = (64'd1 << 62) - 1;
  localparam int          QUIET_LIMIT = 2000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  qpack_static_field_section_parser_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // Shared run state
  token_t      pending_tokens[$];
  token_t      step_tokens[$];
  logic [7:0]  sec[$];
  bit          cut_section;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          hold_req     = 0;
  int unsigned err_count, octets_sent, sections_sent, tokens_checked;
  int unsigned done_tokens, error_tokens;

  // Parser state of the predictor
  phase_t      ps_phase;
  logic [63:0] ps_accum;
  logic [3:0]  ps_cont;
  logic [63:0] ps_left;
  logic [2:0]  ps_flags;   // bit0 N, bit1 H
  logic [2:0]  ps_err;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic void section_clear();
    ps_phase = PH_RIC;
    ps_accum = '0;
    ps_cont  = '0;
    ps_left  = '0;
    ps_flags = '0;
    ps_err   = ERR_NONE;
  endfunction

  function automatic void add_token(logic [2:0] kind, logic [6:0] idx, logic [7:0] data,
                                    logic valid, logic huff, logic never, logic send,
                                    logic [2:0] code);
    token_t t;
    t.token_kind    = kind;
    t.static_index  = idx;
    t.data_byte     = data;
    t.byte_valid    = valid;
    t.huffman_coded = huff;
    t.never_indexed = never;
    t.string_end    = send;
    t.error_code    = code;
    t.run_last      = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void raise_error(logic [2:0] code);
    ps_err   = code;
    ps_phase = PH_DRAIN;
    add_token(KIND_ERROR, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, code);
  endfunction

  function automatic bit int_start(logic [6:0] pv, logic [6:0] mask);
    ps_accum = {57'd0, pv};
    ps_cont  = '0;
    return pv < mask;
  endfunction

  // 1 integer complete, 0 more octets, -1 overflow
  function automatic int int_next(logic [7:0] b);
    logic [63:0] g;
    int          sh;
    g  = {57'd0, b[6:0]};
    sh = 7 * ps_cont;
    if (g != 0) begin
      if (sh >= 62) return -1;
      ps_accum = ps_accum + (g << sh);
      if (ps_accum > QINT_MAX) return -1;
    end
    ps_cont++;
    if (!b[7]) return 1;
    if (ps_cont >= MAX_CONT_OCTETS) return -1;
    return 0;
  endfunction

  function automatic void length_done(bit is_value);
    ps_left = ps_accum;
    if (ps_left == 0) begin
      add_token(is_value ? KIND_VALUE_BYTE : KIND_NAME_BYTE, '0, '0, 1'b0, ps_flags[1],
                ps_flags[0], 1'b1, ERR_NONE);
      if (is_value) ps_phase = PH_LINE;
      else ps_phase = PH_VAL_LEN_FIRST;
    end else if (is_value) begin
      ps_phase = PH_VAL_BYTES;
    end else begin
      ps_phase = PH_NAME_BYTES;
    end
  endfunction

  function automatic void index_done(bit name_ref);
    if (ps_accum >= STATIC_ENTRIES) begin
      raise_error(ERR_RANGE);
    end else if (name_ref) begin
      ps_phase = PH_VAL_LEN_FIRST;
      add_token(KIND_NAME_REF, ps_accum[6:0], '0, 1'b0, 1'b0, ps_flags[0], 1'b0, ERR_NONE);
    end else begin
      ps_phase = PH_LINE;
      add_token(KIND_INDEXED, ps_accum[6:0], '0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE);
    end
  endfunction

  // Works out the tokens one accepted octet causes and queues them
  function automatic void parse_octet(logic [7:0] b, logic last);
    bit     had_err;
    bit     to_value;
    bit     str_end;
    int     r;
    token_t t;
    had_err = (ps_err != ERR_NONE);
    step_tokens.delete();
    if (!had_err) begin
      case (ps_phase)
        PH_RIC: begin
          if (b != 8'h00) raise_error(ERR_PREFIX);
          else ps_phase = PH_DB_FIRST;
        end
        PH_DB_FIRST: begin
          if (b[7]) raise_error(ERR_PREFIX);
          else if (int_start(b[6:0], 7'h7f)) ps_phase = PH_LINE;
          else ps_phase = PH_DB_CONT;
        end
        PH_DB_CONT: begin
          r = int_next(b);
          if (r < 0) raise_error(ERR_OVERFLOW);
          else if (r > 0) ps_phase = PH_LINE;
        end
        PH_LINE: begin
          ps_flags = '0;
          if (b[7]) begin
            if (!b[6]) raise_error(ERR_DYNAMIC);
            else if (int_start({1'b0, b[5:0]}, 7'h3f)) index_done(1'b0);
            else ps_phase = PH_IDX_CONT;
          end else if (b[6]) begin
            if (!b[4]) begin
              raise_error(ERR_DYNAMIC);
            end else begin
              ps_flags = {2'b00, b[5]};
              if (int_start({3'b000, b[3:0]}, 7'h0f)) index_done(1'b1);
              else ps_phase = PH_NREF_CONT;
            end
          end else if (b[5]) begin
            ps_flags = {1'b0, b[3], b[4]};
            if (int_start({4'b0000, b[2:0]}, 7'h07)) length_done(1'b0);
            else ps_phase = PH_NAME_LEN_CONT;
          end else begin
            raise_error(ERR_DYNAMIC);
          end
        end
        PH_IDX_CONT, PH_NREF_CONT: begin
          to_value = (ps_phase == PH_NREF_CONT);
          r = int_next(b);
          if (r < 0) raise_error(ERR_OVERFLOW);
          else if (r > 0) index_done(to_value);
        end
        PH_NAME_LEN_CONT, PH_VAL_LEN_CONT: begin
          to_value = (ps_phase == PH_VAL_LEN_CONT);
          r = int_next(b);
          if (r < 0) raise_error(ERR_OVERFLOW);
          else if (r > 0) length_done(to_value);
        end
        PH_VAL_LEN_FIRST: begin
          ps_flags = {1'b0, b[7], ps_flags[0]};
          if (int_start(b[6:0], 7'h7f)) length_done(1'b1);
          else ps_phase = PH_VAL_LEN_CONT;
        end
        PH_NAME_BYTES, PH_VAL_BYTES: begin
          to_value = (ps_phase == PH_VAL_BYTES);
          str_end  = (ps_left <= 1);
          add_token(to_value ? KIND_VALUE_BYTE : KIND_NAME_BYTE, '0, b, 1'b1, ps_flags[1],
                    ps_flags[0], str_end, ERR_NONE);
          if (str_end) begin
            ps_left = '0;
            if (to_value) ps_phase = PH_LINE;
            else ps_phase = PH_VAL_LEN_FIRST;
          end else begin
            ps_left = ps_left - 64'd1;
          end
        end
        default: raise_error(ERR_TRUNCATED);
      endcase
    end
    // Section end: done at a line boundary, otherwise truncated
    if (last) begin
      if (!had_err && ps_err == ERR_NONE) begin
        if (ps_phase == PH_LINE)
          add_token(KIND_DONE, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE);
        else
          add_token(KIND_ERROR, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, ERR_TRUNCATED);
      end
      section_clear();
    end
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.run_last = (i == step_tokens.size() - 1);
      pending_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin : check_tokens
    token_t got;
    token_t want;
    string  diffs;
    if (!rst && m_tvalid && m_tready) begin
      got.token_kind    = m_tuser;
      got.static_index  = m_tdata[6:0];
      got.data_byte     = m_tdata[14:7];
      got.byte_valid    = m_tdata[15];
      got.huffman_coded = m_tdata[16];
      got.never_indexed = m_tdata[17];
      got.string_end    = m_tdata[18];
      got.error_code    = m_tdata[21:19];
      got.run_last      = m_tlast;
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("token %h with nothing expected", got));
      end else begin
        want  = pending_tokens.pop_front();
        diffs = "";
        if (got.token_kind    !== want.token_kind)    diffs = {diffs, " token_kind"};
        if (got.static_index  !== want.static_index)  diffs = {diffs, " static_index"};
        if (got.data_byte     !== want.data_byte)     diffs = {diffs, " data_byte"};
        if (got.byte_valid    !== want.byte_valid)    diffs = {diffs, " byte_valid"};
        if (got.huffman_coded !== want.huffman_coded) diffs = {diffs, " huffman_coded"};
        if (got.never_indexed !== want.never_indexed) diffs = {diffs, " never_indexed"};
        if (got.string_end    !== want.string_end)    diffs = {diffs, " string_end"};
        if (got.error_code    !== want.error_code)    diffs = {diffs, " error_code"};
        if (got.run_last      !== want.run_last)      diffs = {diffs, " run_last"};
        if (m_tdata[23:22]    !== 2'b00)              diffs = {diffs, " pad_bits"};
        if (diffs != "")
          report_mismatch($sformatf("token %0d:%s got %h want %h", tokens_checked, diffs,
                                    got, want));
        tokens_checked++;
        if (want.token_kind == KIND_DONE) done_tokens++;
        if (want.token_kind == KIND_ERROR) error_tokens++;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin : drive_ready
    int hold_cnt;
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      m_tready <= 1'b0;
      hold_cnt--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d tokens outstanding", quiet,
                 pending_tokens.size());
        $display("tb_qpack_static_field_section_parser_unit: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_octet(input logic [7:0] b, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_octet(b, last);
    octets_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic send_section();
    foreach (sec[i]) send_octet(sec[i], i == sec.size() - 1);
    sections_sent++;
  endtask

  // Sender pauses until every expected token has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  // Prefixed integer with an N-bit prefix; pad adds redundant zero groups
  function automatic void put_int(logic [7:0] pat, int nbits, logic [63:0] v, int pad);
    logic [63:0] mx;
    mx = (64'd1 << nbits) - 1;
    if (v < mx) begin
      sec.push_back(pat | v[7:0]);
    end else begin
      sec.push_back(pat | mx[7:0]);
      v = v - mx;
      while (v >= 128) begin
        sec.push_back({1'b1, v[6:0]});
        v = v >> 7;
      end
      if (pad > 0) begin
        sec.push_back({1'b1, v[6:0]});
        repeat (pad - 1) sec.push_back(8'h80);
        sec.push_back(8'h00);
      end else begin
        sec.push_back({1'b0, v[6:0]});
      end
    end
  endfunction

  function automatic logic [63:0] wild_int();
    case ($urandom_range(3))
      0:       return QINT_MAX;
      1:       return QINT_MAX + 1;
      2:       return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(99) < 6) ? $urandom_range(1, 12) : 0;
  endfunction

  function automatic logic [63:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 88) return 64'($urandom_range(98));
    if (r < 95) return 64'($urandom_range(99, 300));
    return wild_int();
  endfunction

  function automatic logic [63:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 64'($urandom_range(6));
    if (r < 93) return 64'($urandom_range(120, 135));
    return wild_int();
  endfunction

  function automatic logic [63:0] pick_base();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 64'($urandom_range(20));
    if (r < 92) return 64'($urandom_range(127, 5000));
    return wild_int();
  endfunction

  // Huge lengths only get a few octets and end the section early
  function automatic void put_bytes(logic [63:0] len);
    if (len > 300) begin
      repeat ($urandom_range(4)) sec.push_back(8'($urandom_range(255)));
      cut_section = 1'b1;
    end else begin
      repeat (int'(len)) sec.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void put_value();
    logic [63:0] len;
    len = pick_len();
    put_int($urandom_range(1) ? 8'h80 : 8'h00, 7, len, pick_pad());
    put_bytes(len);
  endfunction

  function automatic void mutate_section();
    int n;
    case ($urandom_range(5))
      0: if (sec.size() > 1) begin
        n   = $urandom_range(1, sec.size() - 1);
        sec = sec[0:n-1];
      end
      1: sec[$urandom_range(sec.size() - 1)] = 8'($urandom_range(255));
      2: sec[0] = 8'($urandom_range(1, 255));
      3: if (sec.size() > 1) sec[1] = sec[1] | 8'h80;
      4: case ($urandom_range(2))
        0:       sec.push_back(8'h80 | 8'($urandom_range(63)));
        1:       sec.push_back(8'h40 | (8'($urandom_range(63)) & 8'h2f));
        default: sec.push_back(8'($urandom_range(31)));
      endcase
      default: repeat ($urandom_range(1, 4)) sec.push_back(8'($urandom_range(255)));
    endcase
  endfunction

  // Mostly well-formed sections with random lines, some noise and damage
  function automatic void build_section();
    int          lines;
    logic        never, huff;
    logic [63:0] len;
    sec.delete();
    cut_section = 1'b0;
    if ($urandom_range(99) < 3) begin
      repeat ($urandom_range(1, 8)) sec.push_back(8'($urandom_range(255)));
      return;
    end
    sec.push_back(8'h00);
    put_int(8'h00, 7, pick_base(), pick_pad());
    lines = $urandom_range(4);
    for (int i = 0; i < lines && !cut_section; i++) begin
      never = 1'($urandom_range(1));
      huff  = 1'($urandom_range(1));
      case ($urandom_range(2))
        0: put_int(8'hc0, 6, pick_index(), pick_pad());
        1: begin
          put_int(8'h50 | (never ? 8'h20 : 8'h00), 4, pick_index(), pick_pad());
          put_value();
        end
        default: begin
          len = pick_len();
          put_int(8'h20 | {3'b000, never, huff, 3'b000}, 3, len, pick_pad());
          put_bytes(len);
          if (!cut_section) put_value();
        end
      endcase
    end
    if ($urandom_range(99) < 20) mutate_section();
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // indexed lines at both ends of the static table
    sec = '{8'h00, 8'h00, 8'hc0, 8'hff, 8'h23};
    send_section();
    // nonzero insert count
    sec = '{8'h01};
    send_section();
    // sign bit set in delta base
    sec = '{8'h00, 8'h80};
    send_section();
    // literal name: empty name with N and H, one-octet coded value
    sec = '{8'h00, 8'h00, 8'h38, 8'h81, 8'hff};
    send_section();
    // name reference to the top index, N set, empty value
    sec = '{8'h00, 8'h00, 8'h7f, 8'h53, 8'h00};
    send_section();
    // name reference to the dynamic table
    sec = '{8'h00, 8'h00, 8'h40};
    send_section();
    // index one past the static table
    sec = '{8'h00, 8'h00, 8'hff, 8'h24};
    send_section();
    // delta base that overflows 62 bits
    sec = '{8'h00, 8'h7f};
    repeat (9) sec.push_back(8'hff);
    sec.push_back(8'h00);
    send_section();
    // name string running past the end, then an unfinished prefix
    sec = '{8'h00, 8'h00, 8'h23, 8'h61};
    send_section();
    sec = '{8'h00};
    send_section();
    wait_drained();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_octets);
    int unsigned start;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    start        = octets_sent;
    while (octets_sent - start < n_octets) begin
      build_section();
      send_section();
    end
    wait_drained();
  endtask

  // Receiver holds off long enough for the output queue to fill and stall input
  task automatic test_output_backpressure();
    int unsigned start;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 150;
    start        = octets_sent;
    while (octets_sent - start < 120) begin
      build_section();
      send_section();
    end
    wait_drained();
  endtask

  initial begin
    section_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic(0, 0, 350);
    test_random_traffic(72, 0, 350);
    test_random_traffic(0, 72, 350);
    test_random_traffic(29, 29, 350);
    test_output_backpressure();
    test_random_traffic(0, 0, 150);
    repeat (10) @(posedge clk);
    $display("summary: %0d octets in %0d sections, %0d tokens checked", octets_sent,
             sections_sent, tokens_checked);
    $display("summary: %0d done and %0d error tokens, idle/stall mixes and a long hold-off",
             done_tokens, error_tokens);
    if (err_count == 0) begin
      $display("tb_qpack_static_field_section_parser_unit: clean");
    end else begin
      $display("tb_qpack_static_field_section_parser_unit: errors");
    end
    $finish;
  end

endmodule
